// ===== rtl/sscu_pkg.sv =====
package sscu_pkg;

  localparam int unsigned SegW   = 10;
  localparam int unsigned PauseW = 10;
  localparam int unsigned SweepW = 12;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CoilW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned DivCntW = 4;

  localparam logic [SegW-1:0]   SegStepsReset   = 10'd116;
  localparam logic [PauseW-1:0] PauseTicksReset = 10'd500;
  localparam logic [SweepW-1:0] SweepEndReset   = 12'd4095;

  // Residue of the largest sweep count modulo the reset segment length.
  localparam logic [SegW-1:0]   SegTopRemReset  = SegW'({SweepW{1'b1}} % SegStepsReset);

  localparam logic [PhaseW-1:0] PhaseZero = 4'd0;
  localparam logic [PhaseW-1:0] PhaseHalf = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    RegSegmentSteps = 2'd0,
    RegPauseTicks   = 2'd1,
    RegSweepEnd     = 2'd2,
    RegUnused       = 2'd3
  } cfg_reg_e;

  function automatic logic [CoilW-1:0] coil_lookup(input logic [2:0] idx);
    logic [CoilW-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/stepper_scan_controller_unit.sv =====
// Half-step stepper scan controller, one request per motor tick.
// Input channel: in_valid_i/in_ready_o carry the mode, the start/stop press
// and the two key levels of one tick. Output channel: out_valid_o/out_ready_i
// carry the coil pattern and the sweep status after that tick.
// Each request is worked combinationally and its result is registered in the
// output register on acceptance. One request per cycle is taken while the
// receiver keeps up and no config write or divider run is under way. A new
// request is accepted while the previous result is taken in the same cycle.
// When the receiver stalls, the result stays in the output register and
// in_ready_o drops until it is taken.
// The block tracks the sweep count modulo the segment length incrementally.
// After a write of segment_steps, a bit-serial divider rebuilds that residue,
// and in_ready_o is low while it runs.
// Reset restores the default register values, stops nothing (the run flag
// comes up set), clears the phase and sweep state, and empties the output.
module stepper_scan_controller_unit
  import sscu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                auto_mode_i,
  input  logic                start_stop_press_i,
  input  logic                key_left_level_i,
  input  logic                key_right_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CoilW-1:0]    coil_pattern_o,
  output logic                coil_written_o,
  output logic [SweepW-1:0]   sweep_position_o,
  output logic                sweep_reverse_o,
  output logic                running_o,
  output logic                pausing_o
);

  logic [SegW-1:0]   seg_q;
  logic [PauseW-1:0] pause_ticks_q;
  logic [SweepW-1:0] sweep_end_q;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [SweepW-1:0] cnt_q, cnt_d;
  logic [SegW-1:0]   rem_q, rem_d;
  logic [SegW-1:0]   rem_top_q;
  logic              rev_q, rev_d;
  logic              pf_q, pf_d;
  logic [PauseW-1:0] pc_q, pc_d;
  logic              run_q, run_d;
  logic [SegW-1:0]   mc_q, mc_d;
  logic              klat_q, klat_d;
  logic              ll_q, ll_d;
  logic              rl_q, rl_d;
  logic [CoilW-1:0]  coil_q, coil_d;
  logic              wrote_d;

  logic              out_valid_q;
  logic              wrote_q;

  logic              busy_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [SegW-1:0]   div_rem_q, div_top_q;
  logic [SegW:0]     div_t, div_tt;
  logic [SegW-1:0]   div_rem_n, div_top_n;

  logic in_fire;

  assign in_ready_o = !busy_q && !cfg_we_i && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Bit-serial restoring division of the sweep count and of the top count.
  always_comb begin
    div_t  = {div_rem_q, cnt_q[div_cnt_q]};
    div_tt = {div_top_q, 1'b1};
    if (div_t >= {1'b0, seg_q}) begin
      div_t = div_t - {1'b0, seg_q};
    end
    if (div_tt >= {1'b0, seg_q}) begin
      div_tt = div_tt - {1'b0, seg_q};
    end
    div_rem_n = div_t[SegW-1:0];
    div_top_n = div_tt[SegW-1:0];
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    rev_d   = rev_q;
    pf_d    = pf_q;
    pc_d    = pc_q;
    run_d   = run_q;
    mc_d    = mc_q;
    klat_d  = klat_q;
    ll_d    = ll_q;
    rl_d    = rl_q;
    coil_d  = coil_q;
    wrote_d = 1'b0;

    if (auto_mode_i) begin
      if (start_stop_press_i) begin
        run_d = !run_q;
      end
      if (seg_q != '0 && cnt_q != '0 && rem_q == '0) begin
        pf_d = 1'b1;
        pc_d = pc_q + 1'b1;
        if (pc_d == pause_ticks_q) begin
          pc_d = '0;
          pf_d = 1'b0;
        end
      end
      if (!pf_d && run_d) begin
        if (!rev_d) begin
          coil_d  = coil_lookup(phase_d[2:0]);
          phase_d = phase_d + 1'b1;
          wrote_d = 1'b1;
          if (cnt_d == '1) begin
            rem_d = '0;
          end else if ({1'b0, rem_d} + 1'b1 == {1'b0, seg_q}) begin
            rem_d = '0;
          end else begin
            rem_d = rem_d + 1'b1;
          end
          cnt_d = cnt_d + 1'b1;
          if (phase_d == PhaseHalf) begin
            phase_d = PhaseZero;
          end
          if (cnt_d == sweep_end_q) begin
            rev_d   = 1'b1;
            phase_d = PhaseHalf;
          end
        end
        if (rev_d) begin
          coil_d  = coil_lookup(phase_d[2:0] - 3'd1);
          phase_d = phase_d - 1'b1;
          wrote_d = 1'b1;
          if (cnt_d == '0) begin
            rem_d = rem_top_q;
          end else if (rem_d == '0) begin
            rem_d = seg_q - 1'b1;
          end else begin
            rem_d = rem_d - 1'b1;
          end
          cnt_d = cnt_d - 1'b1;
          if (phase_d == PhaseZero) begin
            phase_d = PhaseHalf;
          end
          if (cnt_d == '0) begin
            rev_d   = 1'b0;
            phase_d = PhaseZero;
          end
        end
      end
    end else begin
      if (!klat_q) begin
        ll_d   = key_left_level_i;
        rl_d   = key_right_level_i;
        klat_d = 1'b1;
      end
      if (!ll_d && key_left_level_i) begin
        if (phase_d == PhaseZero) begin
          phase_d = PhaseHalf;
        end
        coil_d  = coil_lookup(phase_d[2:0] - 3'd1);
        phase_d = phase_d - 1'b1;
        wrote_d = 1'b1;
        if (phase_d == PhaseZero) begin
          phase_d = PhaseHalf;
        end
        mc_d = mc_q + 1'b1;
        if (mc_d == seg_q) begin
          mc_d    = '0;
          phase_d = PhaseZero;
          klat_d  = 1'b0;
        end
      end else if (!rl_d && key_right_level_i) begin
        if (phase_d == PhaseHalf) begin
          phase_d = PhaseZero;
        end
        coil_d  = coil_lookup(phase_d[2:0]);
        phase_d = phase_d + 1'b1;
        wrote_d = 1'b1;
        if (phase_d[3]) begin
          phase_d = PhaseZero;
        end
        mc_d = mc_q + 1'b1;
        if (mc_d == seg_q) begin
          mc_d    = '0;
          phase_d = PhaseZero;
          klat_d  = 1'b0;
        end
      end
      if (ll_d && rl_d) begin
        klat_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q         <= SegStepsReset;
      pause_ticks_q <= PauseTicksReset;
      sweep_end_q   <= SweepEndReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegSegmentSteps: seg_q         <= cfg_data_i[SegW-1:0];
        RegPauseTicks:   pause_ticks_q <= cfg_data_i[PauseW-1:0];
        RegSweepEnd:     sweep_end_q   <= cfg_data_i[SweepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      div_cnt_q <= '0;
      div_rem_q <= '0;
      div_top_q <= '0;
    end else if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == RegSegmentSteps) begin
      busy_q    <= 1'b1;
      div_cnt_q <= DivCntW'(SweepW - 1);
      div_rem_q <= '0;
      div_top_q <= '0;
    end else if (busy_q) begin
      div_rem_q <= div_rem_n;
      div_top_q <= div_top_n;
      div_cnt_q <= div_cnt_q - 1'b1;
      if (div_cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      rem_top_q <= SegTopRemReset;
      rev_q     <= 1'b0;
      pf_q      <= 1'b0;
      pc_q      <= '0;
      run_q     <= 1'b1;
      mc_q      <= '0;
      klat_q    <= 1'b0;
      ll_q      <= 1'b1;
      rl_q      <= 1'b1;
      coil_q    <= '0;
    end else if (busy_q) begin
      if (div_cnt_q == '0) begin
        rem_q     <= div_rem_n;
        rem_top_q <= div_top_n;
      end
    end else if (in_fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      rev_q   <= rev_d;
      pf_q    <= pf_d;
      pc_q    <= pc_d;
      run_q   <= run_d;
      mc_q    <= mc_d;
      klat_q  <= klat_d;
      ll_q    <= ll_d;
      rl_q    <= rl_d;
      coil_q  <= coil_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wrote_q     <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
      wrote_q     <= wrote_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign coil_pattern_o   = coil_q;
  assign coil_written_o   = wrote_q;
  assign sweep_position_o = cnt_q;
  assign sweep_reverse_o  = rev_q;
  assign running_o        = run_q;
  assign pausing_o        = pf_q;

endmodule

// ===== tb/stepper_scan_controller_unit_tb.sv =====
module stepper_scan_controller_unit_tb;
  import sscu_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [31:0] HalfStepPats = 32'h98C4_6231;

  typedef struct packed {
    logic auto_mode;
    logic press;
    logic key_l;
    logic key_r;
  } tick_t;

  typedef struct packed {
    logic [CoilW-1:0]  coil;
    logic              written;
    logic [SweepW-1:0] pos;
    logic              rev;
    logic              run;
    logic              pause;
  } drive_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegSegmentSteps;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                auto_mode_i = 1'b0;
  logic                start_stop_press_i = 1'b0;
  logic                key_left_level_i = 1'b1;
  logic                key_right_level_i = 1'b1;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CoilW-1:0]    coil_pattern_o;
  logic                coil_written_o;
  logic [SweepW-1:0]   sweep_position_o;
  logic                sweep_reverse_o;
  logic                running_o;
  logic                pausing_o;

  stepper_scan_controller_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .auto_mode_i        (auto_mode_i),
    .start_stop_press_i (start_stop_press_i),
    .key_left_level_i   (key_left_level_i),
    .key_right_level_i  (key_right_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .coil_pattern_o     (coil_pattern_o),
    .coil_written_o     (coil_written_o),
    .sweep_position_o   (sweep_position_o),
    .sweep_reverse_o    (sweep_reverse_o),
    .running_o          (running_o),
    .pausing_o          (pausing_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Motor state tracked alongside the block.
  logic [SegW-1:0]   seg_len = SegStepsReset;
  logic [PauseW-1:0] pause_len = PauseTicksReset;
  logic [SweepW-1:0] turn_pos = SweepEndReset;
  logic [PhaseW-1:0] mtr_phase = PhaseZero;
  logic [SweepW-1:0] mtr_pos = '0;
  logic              mtr_rev = 1'b0;
  logic              mtr_paused = 1'b0;
  logic [PauseW-1:0] mtr_pause_cnt = '0;
  logic              mtr_run = 1'b1;
  logic [SegW-1:0]   mtr_seg_cnt = '0;
  logic              mtr_latched = 1'b0;
  logic              mtr_left = 1'b1;
  logic              mtr_right = 1'b1;
  logic [CoilW-1:0]  mtr_coil = '0;

  tick_t         tick_q[$];
  drive_status_t status_q[$];
  tick_t         offered;
  drive_status_t want;
  bit            idle_on = 1'b1;
  int unsigned   tx_gap = 0;
  int unsigned   rx_gap = 0;
  int unsigned   rx_hold = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;

  function automatic void step_fwd();
    mtr_coil = HalfStepPats[4*mtr_phase[2:0] +: 4];
    mtr_phase = mtr_phase + 4'd1;
  endfunction

  function automatic void step_back();
    logic [2:0] idx;
    idx = mtr_phase[2:0] - 3'd1;
    mtr_coil = HalfStepPats[4*idx +: 4];
    mtr_phase = mtr_phase - 4'd1;
  endfunction

  function automatic void count_segment_step();
    mtr_seg_cnt = mtr_seg_cnt + 10'd1;
    if (mtr_seg_cnt == seg_len) begin
      mtr_seg_cnt = '0;
      mtr_phase = PhaseZero;
      mtr_latched = 1'b0;
    end
  endfunction

  function automatic drive_status_t advance_motor(tick_t t);
    drive_status_t s;
    logic wrote;
    wrote = 1'b0;
    if (t.auto_mode && t.press) mtr_run = !mtr_run;
    if (t.auto_mode) begin
      if (seg_len != 0 && mtr_pos != 0 && (mtr_pos % seg_len) == 0) begin
        mtr_paused = 1'b1;
        mtr_pause_cnt = mtr_pause_cnt + 10'd1;
        if (mtr_pause_cnt == pause_len) begin
          mtr_pause_cnt = '0;
          mtr_paused = 1'b0;
        end
      end
      if (!mtr_paused && mtr_run) begin
        if (!mtr_rev) begin
          step_fwd();
          wrote = 1'b1;
          mtr_pos = mtr_pos + 12'd1;
          if (mtr_phase == PhaseHalf) mtr_phase = PhaseZero;
          if (mtr_pos == turn_pos) begin
            mtr_rev = 1'b1;
            mtr_phase = PhaseHalf;
          end
        end
        if (mtr_rev) begin
          step_back();
          wrote = 1'b1;
          mtr_pos = mtr_pos - 12'd1;
          if (mtr_phase == PhaseZero) mtr_phase = PhaseHalf;
          if (mtr_pos == 0) begin
            mtr_rev = 1'b0;
            mtr_phase = PhaseZero;
          end
        end
      end
    end else begin
      if (!mtr_latched) begin
        mtr_left = t.key_l;
        mtr_right = t.key_r;
        mtr_latched = 1'b1;
      end
      if (!mtr_left && t.key_l) begin
        if (mtr_phase == PhaseZero) mtr_phase = PhaseHalf;
        step_back();
        wrote = 1'b1;
        if (mtr_phase == PhaseZero) mtr_phase = PhaseHalf;
        count_segment_step();
      end else if (!mtr_right && t.key_r) begin
        if (mtr_phase == PhaseHalf) mtr_phase = PhaseZero;
        step_fwd();
        wrote = 1'b1;
        if (mtr_phase >= PhaseHalf) mtr_phase = PhaseZero;
        count_segment_step();
      end
      if (mtr_left && mtr_right) mtr_latched = 1'b0;
    end
    s.coil = mtr_coil;
    s.written = wrote;
    s.pos = mtr_pos;
    s.rev = mtr_rev;
    s.run = mtr_run;
    s.pause = mtr_paused;
    return s;
  endfunction

  function automatic void push_tick(logic m, logic p, logic l, logic r);
    tick_t t;
    t.auto_mode = m;
    t.press = p;
    t.key_l = l;
    t.key_r = r;
    tick_q.push_back(t);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) status_q.push_back(advance_motor(offered));
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else begin
          offered = tick_q.pop_front();
          in_valid_i <= 1'b1;
          auto_mode_i <= offered.auto_mode;
          start_stop_press_i <= offered.press;
          key_left_level_i <= offered.key_l;
          key_right_level_i <= offered.key_r;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap = 0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (results_seen == 400) rx_hold = 150;
        if (status_q.size() == 0) begin
          $error("unexpected result: coil_pattern %0h", coil_pattern_o);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          if (coil_pattern_o !== want.coil) begin
            $error("coil_pattern: expected %0h, got %0h", want.coil, coil_pattern_o);
            mismatches++;
          end
          if (coil_written_o !== want.written) begin
            $error("coil_written: expected %0d, got %0d", want.written, coil_written_o);
            mismatches++;
          end
          if (sweep_position_o !== want.pos) begin
            $error("sweep_position: expected %0d, got %0d", want.pos, sweep_position_o);
            mismatches++;
          end
          if (sweep_reverse_o !== want.rev) begin
            $error("sweep_reverse: expected %0d, got %0d", want.rev, sweep_reverse_o);
            mismatches++;
          end
          if (running_o !== want.run) begin
            $error("running: expected %0d, got %0d", want.run, running_o);
            mismatches++;
          end
          if (pausing_o !== want.pause) begin
            $error("pausing: expected %0d, got %0d", want.pause, pausing_o);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || status_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegSegmentSteps: seg_len = val[SegW-1:0];
      RegPauseTicks:   pause_len = val[PauseW-1:0];
      RegSweepEnd:     turn_pos = val[SweepW-1:0];
      default: ;
    endcase
  endtask

  // Reconfigures once the block has drained, then queues random requests:
  // mostly auto runs and manual press/release sequences, plus some noise.
  task automatic run_phase(input int unsigned seg, input int unsigned pause,
                           input int unsigned turn, input int unsigned n,
                           input int unsigned auto_pct, input bit idle);
    int unsigned kind;
    int unsigned span;
    bit left_side;
    wait_drained();
    idle_on = idle;
    write_reg(RegPauseTicks, pause[CfgDataW-1:0]);
    write_reg(RegSweepEnd, turn[CfgDataW-1:0]);
    write_reg(RegSegmentSteps, seg[CfgDataW-1:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span = (seg > 18) ? 40 : 2 * seg + 3;
    while (tick_q.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < auto_pct) begin
        repeat ($urandom_range(5, 40))
          push_tick(1'b1, $urandom_range(0, 39) == 0, $urandom_range(0, 1) != 0,
                    $urandom_range(0, 1) != 0);
      end else if (kind < 95) begin
        left_side = $urandom_range(0, 1) != 0;
        repeat ($urandom_range(1, 3))
          push_tick(1'b0, $urandom_range(0, 1) != 0, !left_side,
                    left_side ? $urandom_range(0, 1) != 0 : 1'b0);
        repeat ($urandom_range(1, span))
          push_tick(1'b0, $urandom_range(0, 1) != 0, $urandom_range(0, 7) != 0,
                    $urandom_range(0, 7) != 0);
      end else begin
        repeat ($urandom_range(1, 8))
          push_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                    $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // At reset settings: run, stop, stopped tick, press in manual mode, run again.
    push_tick(1'b1, 1'b0, 1'b1, 1'b1);
    push_tick(1'b1, 1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b1, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1, 1'b0);

    // Short segments: right, left and both-keys segments, then an auto sweep
    // that turns at the end with two steps and pauses at a boundary.
    run_phase(2, 3, 4, 0, 0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    repeat (12) push_tick(1'b1, 1'b0, 1'b1, 1'b1);

    run_phase(3, 2, 10, 200, 50, 1'b1);
    run_phase(1023, 1023, 1, 100, 50, 1'b0);
    run_phase(0, 1, 4095, 150, 50, 1'b1);
    run_phase(2, 0, 5, 300, 90, 1'b1);
    run_phase(5, 3, 3, 300, 60, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sscu_pkg.sv
rtl/stepper_scan_controller_unit.sv
tb/stepper_scan_controller_unit_tb.sv
